[hdl/dcp_pkg.sv]
// ============================================================================
// dcp_pkg
// shared constants, types and helper functions of the depthwise plane unit
// ============================================================================
package dcp_pkg;

    // plane and kernel limits
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_KERNEL = 8;

    // store geometry
    localparam int PIX_DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int WGT_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int WGT_AW    = $clog2(WGT_DEPTH);

    // field widths
    localparam int DIM_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int MODE_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 40;
    localparam int CFG_AW   = 3;

    // counters and coordinates
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int KI_W     = $clog2(MAX_KERNEL);
    localparam int KK_W     = $clog2(WGT_DEPTH + 1);
    localparam int NPIX_W   = $clog2(PIX_DEPTH + 1);
    localparam int MAX_DIM  = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
    localparam int COORD_W  = $clog2(MAX_DIM * 15 + MAX_KERNEL * 15) + 1;

    // request modes
    localparam logic [MODE_W-1:0] MODE_LOAD_WEIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_PIXEL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMIT        = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED      = 2'd3;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_IN_HEIGHT  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_IN_WIDTH   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_OUT_HEIGHT = 3'd2;
    localparam logic [CFG_AW-1:0] REG_OUT_WIDTH  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_KERNEL     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_PAD        = 3'd5;
    localparam logic [CFG_AW-1:0] REG_STRIDE     = 3'd6;
    localparam logic [CFG_AW-1:0] REG_DILATION   = 3'd7;

    // effective geometry after clamping
    typedef struct packed {
        logic [DIM_W-1:0]  ih;
        logic [DIM_W-1:0]  iw;
        logic [DIM_W-1:0]  oh;
        logic [DIM_W-1:0]  ow;
        logic [NIB_W-1:0]  kh;
        logic [NIB_W-1:0]  kw;
        logic [NIB_W-1:0]  pt;
        logic [NIB_W-1:0]  pl;
        logic [NIB_W-1:0]  sv;
        logic [NIB_W-1:0]  sh;
        logic [NIB_W-1:0]  dv;
        logic [NIB_W-1:0]  dh;
        logic [KK_W-1:0]   kern_taps;
        logic [NPIX_W-1:0] plane_pixels;
    } geom_t;

    // one kernel tap on its way to the multiplier
    typedef struct packed {
        logic              vld;
        logic              in_plane;
        logic              last;
        logic [PIX_AW-1:0] pix_addr;
        logic [WGT_AW-1:0] wgt_addr;
    } tap_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [NIB_W-1:0] clamp_kernel(input logic [NIB_W-1:0] v);
        logic [NIB_W-1:0] r;
        if (v == '0)
            r = NIB_W'(1);
        else if (v > NIB_W'(MAX_KERNEL))
            r = NIB_W'(MAX_KERNEL);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [NIB_W-1:0] at_least_one(input logic [NIB_W-1:0] v);
        return (v == '0) ? NIB_W'(1) : v;
    endfunction

endpackage

[hdl/dcp_store.sv]
// ============================================================================
// dcp_store
// weight and pixel memories with raster load pointers and registered reads
// ============================================================================
module dcp_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_weight,
    input  logic                          wr_pixel,
    input  logic [dcp_pkg::SAMPLE_W-1:0]  sample,
    input  dcp_pkg::geom_t                geom,
    input  logic                          rd_en,
    input  logic [dcp_pkg::WGT_AW-1:0]    wgt_addr,
    input  logic [dcp_pkg::PIX_AW-1:0]    pix_addr,
    output logic [dcp_pkg::SAMPLE_W-1:0]  wgt_data,
    output logic [dcp_pkg::SAMPLE_W-1:0]  pix_data
);

    logic [dcp_pkg::SAMPLE_W-1:0] wgt_mem [dcp_pkg::WGT_DEPTH];
    logic [dcp_pkg::SAMPLE_W-1:0] pix_mem [dcp_pkg::PIX_DEPTH];

    logic [dcp_pkg::WGT_AW-1:0] wptr_reg, wptr_next, wptr_eff;
    logic [dcp_pkg::PIX_AW-1:0] pptr_reg, pptr_next, pptr_eff;
    logic [dcp_pkg::KK_W-1:0]   wptr_inc;
    logic [dcp_pkg::NPIX_W-1:0] pptr_inc;

    // wrap a stale pointer before the write, then again after the advance
    always_comb
    begin
        wptr_eff  = (dcp_pkg::KK_W'(wptr_reg) >= geom.kern_taps) ? '0 : wptr_reg;
        wptr_inc  = dcp_pkg::KK_W'(wptr_eff) + 1'b1;
        wptr_next = (wptr_inc >= geom.kern_taps) ? '0 : wptr_inc[dcp_pkg::WGT_AW-1:0];

        pptr_eff  = (dcp_pkg::NPIX_W'(pptr_reg) >= geom.plane_pixels) ? '0 : pptr_reg;
        pptr_inc  = dcp_pkg::NPIX_W'(pptr_eff) + 1'b1;
        pptr_next = (pptr_inc >= geom.plane_pixels) ? '0 : pptr_inc[dcp_pkg::PIX_AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            pptr_reg <= '0;
        end
        else
        begin
            if (wr_weight)
                wptr_reg <= wptr_next;
            if (wr_pixel)
                pptr_reg <= pptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_weight)
            wgt_mem[wptr_eff] <= sample;
        if (rd_en)
            wgt_data <= wgt_mem[wgt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_pixel)
            pix_mem[pptr_eff] <= sample;
        if (rd_en)
            pix_data <= pix_mem[pix_addr];
    end

endmodule

[hdl/dcp_tap_seq.sv]
// ============================================================================
// dcp_tap_seq
// output position tracking and kernel tap sequencer
// ============================================================================
module dcp_tap_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           emit_req,
    input  dcp_pkg::geom_t geom,
    input  logic           result_done,
    output logic           busy,
    output dcp_pkg::tap_t  tap,
    output logic           plane_last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_TAPS  = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [dcp_pkg::ROW_W-1:0]   out_row_reg, out_row_next;
    logic [dcp_pkg::COL_W-1:0]   out_col_reg, out_col_next;
    logic [dcp_pkg::KI_W-1:0]    a_reg, a_next;
    logic [dcp_pkg::KI_W-1:0]    b_reg, b_next;
    logic [dcp_pkg::WGT_AW-1:0]  w_reg, w_next;
    logic [dcp_pkg::COORD_W-1:0] r_reg, r_next;
    logic [dcp_pkg::COORD_W-1:0] c_reg, c_next;
    logic [dcp_pkg::COORD_W-1:0] c0_reg, c0_next;
    logic                        plane_last_reg, plane_last_next;
    dcp_pkg::tap_t               tap_reg, tap_next;

    logic [dcp_pkg::ROW_W+dcp_pkg::NIB_W-1:0] row_scaled;
    logic [dcp_pkg::COL_W+dcp_pkg::NIB_W-1:0] col_scaled;
    logic [dcp_pkg::COORD_W-1:0]              r_start, c_start;
    logic                                     pos_last, col_wrap;
    logic                                     b_end, a_end, in_plane;
    logic [dcp_pkg::ROW_W+dcp_pkg::DIM_W-1:0] pix_lin;

    always_comb
    begin
        row_scaled = out_row_reg * geom.sv;
        col_scaled = out_col_reg * geom.sh;
        r_start    = dcp_pkg::COORD_W'(row_scaled) - dcp_pkg::COORD_W'(geom.pt);
        c_start    = dcp_pkg::COORD_W'(col_scaled) - dcp_pkg::COORD_W'(geom.pl);
        col_wrap   = (dcp_pkg::DIM_W'(out_col_reg) + 1'b1) >= geom.ow;
        pos_last   = ((dcp_pkg::DIM_W'(out_row_reg) + 1'b1) >= geom.oh) && col_wrap;

        b_end = (dcp_pkg::NIB_W'(b_reg) + 1'b1) == geom.kw;
        a_end = (dcp_pkg::NIB_W'(a_reg) + 1'b1) == geom.kh;

        // sign bit clear and below the plane size on both axes
        in_plane = !r_reg[dcp_pkg::COORD_W-1] && (r_reg < dcp_pkg::COORD_W'(geom.ih)) &&
                   !c_reg[dcp_pkg::COORD_W-1] && (c_reg < dcp_pkg::COORD_W'(geom.iw));
        pix_lin = r_reg[dcp_pkg::ROW_W-1:0] * geom.iw
                + (dcp_pkg::ROW_W+dcp_pkg::DIM_W)'(c_reg[dcp_pkg::COL_W-1:0]);
    end

    always_comb
    begin
        state_next      = state_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        c0_next         = c0_reg;
        plane_last_next = plane_last_reg;
        tap_next        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (emit_req)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                r_next          = r_start;
                c_next          = c_start;
                c0_next         = c_start;
                a_next          = '0;
                b_next          = '0;
                w_next          = '0;
                plane_last_next = pos_last;
                if (pos_last)
                begin
                    out_row_next = '0;
                    out_col_next = '0;
                end
                else if (col_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
                state_next = S_TAPS;
            end
            S_TAPS:
            begin
                tap_next.vld      = 1'b1;
                tap_next.in_plane = in_plane;
                tap_next.last     = a_end && b_end;
                tap_next.pix_addr = pix_lin[dcp_pkg::PIX_AW-1:0];
                tap_next.wgt_addr = w_reg;
                w_next            = w_reg + 1'b1;
                if (b_end)
                begin
                    b_next = '0;
                    a_next = a_reg + 1'b1;
                    c_next = c0_reg;
                    r_next = r_reg + dcp_pkg::COORD_W'(geom.dv);
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                    c_next = c_reg + dcp_pkg::COORD_W'(geom.dh);
                end
                if (a_end && b_end)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (result_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            plane_last_reg <= 1'b0;
            tap_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            plane_last_reg <= plane_last_next;
            tap_reg        <= tap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        w_reg  <= w_next;
        r_reg  <= r_next;
        c_reg  <= c_next;
        c0_reg <= c0_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign tap        = tap_reg;
    assign plane_last = plane_last_reg;

endmodule

[hdl/dcp_mac.sv]
// ============================================================================
// dcp_mac
// shared multiplier and 40-bit accumulator for the kernel taps
// ============================================================================
module dcp_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dcp_pkg::tap_t                 tap,
    input  logic [dcp_pkg::SAMPLE_W-1:0]  wgt_data,
    input  logic [dcp_pkg::SAMPLE_W-1:0]  pix_data,
    input  logic                          plane_last,
    output logic                          result_valid,
    output logic [dcp_pkg::ACC_W-1:0]     out_value,
    output logic                          last_of_plane
);

    // flags aligned with the registered memory read
    logic use_rd_reg, last_rd_reg;
    // flags aligned with the product register
    logic last_mul_reg;
    logic signed [dcp_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [dcp_pkg::ACC_W-1:0]         acc_reg, acc_sum, prod_ext;
    logic                              result_valid_reg;
    logic [dcp_pkg::ACC_W-1:0]         out_value_reg;
    logic                              last_of_plane_reg;

    always_comb
    begin
        // signed 16x16 product, zero for padding taps
        prod_next = '0;
        if (use_rd_reg)
            prod_next = $signed(wgt_data) * $signed(pix_data);
        prod_ext  = {{(dcp_pkg::ACC_W-dcp_pkg::PROD_W){prod_reg[dcp_pkg::PROD_W-1]}},
                     prod_reg};
        acc_sum   = acc_reg + prod_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_rd_reg       <= 1'b0;
            last_rd_reg      <= 1'b0;
            last_mul_reg     <= 1'b0;
            prod_reg         <= '0;
            acc_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            use_rd_reg       <= tap.vld && tap.in_plane;
            last_rd_reg      <= tap.vld && tap.last;
            last_mul_reg     <= last_rd_reg;
            prod_reg         <= prod_next;
            acc_reg          <= last_mul_reg ? '0 : acc_sum;
            result_valid_reg <= last_mul_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_mul_reg)
        begin
            out_value_reg     <= acc_sum;
            last_of_plane_reg <= plane_last;
        end
    end

    assign result_valid  = result_valid_reg;
    assign out_value     = out_value_reg;
    assign last_of_plane = last_of_plane_reg;

endmodule

[hdl/depthwise_conv2d_plane_unit.sv]
// ============================================================================
// depthwise_conv2d_plane_unit
// one channel plane of a depthwise 2d convolution with padding, stride, dilation
// ============================================================================
// a request is taken when start is high and busy is low. mode 0 stores the
// next kernel weight (q2.14) and mode 1 the next input pixel, both in raster
// order; busy never rises for these. mode 2 computes the next output
// position in raster order: busy rises through a setup step, the kernel
// taps at one per cycle through the single 16x16 multiplier, then read,
// multiply, accumulate and return to idle, and the result shows on out_value
// and last_of_plane for exactly one cycle with result_valid high, before busy
// falls. the receiver cannot stall, so take the result in that cycle. mode 3
// is ignored. configuration writes are always accepted and must only be
// issued while busy is low.
// ============================================================================
module depthwise_conv2d_plane_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic [dcp_pkg::MODE_W-1:0]    mode,
    input  logic [dcp_pkg::SAMPLE_W-1:0]  sample,
    // result channel
    output logic                          result_valid,
    output logic [dcp_pkg::ACC_W-1:0]     out_value,
    output logic                          last_of_plane,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dcp_pkg::CFG_AW-1:0]    cfg_index,
    input  logic [dcp_pkg::BYTE_W-1:0]    cfg_data
);

    // raw configuration registers, clamped on use
    logic [dcp_pkg::DIM_W-1:0]  in_height_reg, in_width_reg;
    logic [dcp_pkg::DIM_W-1:0]  out_height_reg, out_width_reg;
    logic [dcp_pkg::BYTE_W-1:0] kernel_size_reg, pad_origin_reg;
    logic [dcp_pkg::BYTE_W-1:0] stride_steps_reg, dilation_steps_reg;

    dcp_pkg::geom_t geom;
    dcp_pkg::tap_t  tap;

    logic accept, wr_weight, wr_pixel, emit_req, cfg_write;
    logic seq_busy, plane_last;
    logic [dcp_pkg::SAMPLE_W-1:0] wgt_data, pix_data;
    logic [2*dcp_pkg::NIB_W-1:0]  kern_prod;
    logic [2*dcp_pkg::DIM_W-1:0]  plane_prod;

    // request decode
    assign accept    = start && !seq_busy;
    assign wr_weight = accept && (mode == dcp_pkg::MODE_LOAD_WEIGHT);
    assign wr_pixel  = accept && (mode == dcp_pkg::MODE_LOAD_PIXEL);
    assign emit_req  = accept && (mode == dcp_pkg::MODE_EMIT);

    // configuration port never stalls
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg      <= dcp_pkg::DIM_W'(64);
            in_width_reg       <= dcp_pkg::DIM_W'(64);
            out_height_reg     <= dcp_pkg::DIM_W'(62);
            out_width_reg      <= dcp_pkg::DIM_W'(62);
            kernel_size_reg    <= 8'h33;
            pad_origin_reg     <= 8'h00;
            stride_steps_reg   <= 8'h11;
            dilation_steps_reg <= 8'h11;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dcp_pkg::REG_IN_HEIGHT:  in_height_reg      <= cfg_data[dcp_pkg::DIM_W-1:0];
                dcp_pkg::REG_IN_WIDTH:   in_width_reg       <= cfg_data[dcp_pkg::DIM_W-1:0];
                dcp_pkg::REG_OUT_HEIGHT: out_height_reg     <= cfg_data[dcp_pkg::DIM_W-1:0];
                dcp_pkg::REG_OUT_WIDTH:  out_width_reg      <= cfg_data[dcp_pkg::DIM_W-1:0];
                dcp_pkg::REG_KERNEL:     kernel_size_reg    <= cfg_data;
                dcp_pkg::REG_PAD:        pad_origin_reg     <= cfg_data;
                dcp_pkg::REG_STRIDE:     stride_steps_reg   <= cfg_data;
                dcp_pkg::REG_DILATION:   dilation_steps_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // effective geometry: zero sizes count as one, oversize saturates
    always_comb
    begin
        geom.ih = dcp_pkg::clamp_dim(in_height_reg,  dcp_pkg::DIM_W'(dcp_pkg::MAX_HEIGHT));
        geom.iw = dcp_pkg::clamp_dim(in_width_reg,   dcp_pkg::DIM_W'(dcp_pkg::MAX_WIDTH));
        geom.oh = dcp_pkg::clamp_dim(out_height_reg, dcp_pkg::DIM_W'(dcp_pkg::MAX_HEIGHT));
        geom.ow = dcp_pkg::clamp_dim(out_width_reg,  dcp_pkg::DIM_W'(dcp_pkg::MAX_WIDTH));
        geom.kh = dcp_pkg::clamp_kernel(kernel_size_reg[7:4]);
        geom.kw = dcp_pkg::clamp_kernel(kernel_size_reg[3:0]);
        geom.pt = pad_origin_reg[7:4];
        geom.pl = pad_origin_reg[3:0];
        geom.sv = dcp_pkg::at_least_one(stride_steps_reg[7:4]);
        geom.sh = dcp_pkg::at_least_one(stride_steps_reg[3:0]);
        geom.dv = dcp_pkg::at_least_one(dilation_steps_reg[7:4]);
        geom.dh = dcp_pkg::at_least_one(dilation_steps_reg[3:0]);
        // element counts that bound the load pointers
        kern_prod         = geom.kh * geom.kw;
        plane_prod        = geom.ih * geom.iw;
        geom.kern_taps    = dcp_pkg::KK_W'(kern_prod);
        geom.plane_pixels = dcp_pkg::NPIX_W'(plane_prod);
    end

    // sequencer walks the kernel taps of one output position
    dcp_tap_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .emit_req    (emit_req),
        .geom        (geom),
        .result_done (result_valid),
        .busy        (seq_busy),
        .tap         (tap),
        .plane_last  (plane_last)
    );

    // weight and pixel memories, read one tap per cycle
    dcp_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_weight (wr_weight),
        .wr_pixel  (wr_pixel),
        .sample    (sample),
        .geom      (geom),
        .rd_en     (tap.vld),
        .wgt_addr  (tap.wgt_addr),
        .pix_addr  (tap.pix_addr),
        .wgt_data  (wgt_data),
        .pix_data  (pix_data)
    );

    // shared multiply-accumulate; taps outside the plane add zero
    dcp_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .tap           (tap),
        .wgt_data      (wgt_data),
        .pix_data      (pix_data),
        .plane_last    (plane_last),
        .result_valid  (result_valid),
        .out_value     (out_value),
        .last_of_plane (last_of_plane)
    );

    assign busy = seq_busy;

    // a result only appears while an emit request is in flight
    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
    else $error("result strobe outside an emit request");

    // results are single-cycle strobes
    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

    // an accepted emit request makes the unit busy next cycle
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == dcp_pkg::MODE_EMIT)) |=> busy)
    else $error("emit request did not start the sequencer");

    // loads never raise busy
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode != dcp_pkg::MODE_EMIT)) |=> !busy)
    else $error("load request raised busy");

endmodule

[sim/depthwise_conv2d_plane_unit_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// depthwise_conv2d_plane_unit_tb
// drives weight loads, pixel loads and output requests through a series of
// plane settings and checks every output sum and end-of-plane flag against
// a bit-exact predictor of the convolution
// ============================================================================

class conv_plane_scoreboard;
    // register copies
    logic [dcp_pkg::DIM_W-1:0]  in_h, in_w, out_h, out_w;
    logic [dcp_pkg::BYTE_W-1:0] kern_reg, pad_reg, stride_reg, dil_reg;

    // stores and what has been written so far
    logic signed [dcp_pkg::SAMPLE_W-1:0] weights [dcp_pkg::WGT_DEPTH];
    logic signed [dcp_pkg::SAMPLE_W-1:0] pixels [dcp_pkg::PIX_DEPTH];
    bit weight_loaded [dcp_pkg::WGT_DEPTH];
    bit pixel_loaded [dcp_pkg::PIX_DEPTH];
    int weight_ptr, pixel_ptr, row, col;

    // outputs still owed by the block
    logic [dcp_pkg::ACC_W-1:0] pending_sums [$];
    bit pending_last_flags [$];

    int errors;
    int outputs_checked;
    int planes_closed;

    function new();
        in_h = 7'd64;
        in_w = 7'd64;
        out_h = 7'd62;
        out_w = 7'd62;
        kern_reg = 8'h33;
        pad_reg = 8'h00;
        stride_reg = 8'h11;
        dil_reg = 8'h11;
        weight_ptr = 0;
        pixel_ptr = 0;
        row = 0;
        col = 0;
        errors = 0;
        outputs_checked = 0;
        planes_closed = 0;
    endfunction

    function int clamp_size(logic [dcp_pkg::DIM_W-1:0] v, int bound);
        if (v == '0)
            return 1;
        if (int'(v) > bound)
            return bound;
        return int'(v);
    endfunction

    function int clamp_tap(logic [dcp_pkg::NIB_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > dcp_pkg::MAX_KERNEL)
            return dcp_pkg::MAX_KERNEL;
        return int'(v);
    endfunction

    function int nonzero(logic [dcp_pkg::NIB_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function int kernel_taps();
        return clamp_tap(kern_reg[7:4]) * clamp_tap(kern_reg[3:0]);
    endfunction

    function int plane_pixels();
        return clamp_size(in_h, dcp_pkg::MAX_HEIGHT) * clamp_size(in_w, dcp_pkg::MAX_WIDTH);
    endfunction

    function void write_register(logic [dcp_pkg::CFG_AW-1:0] idx,
                                 logic [dcp_pkg::BYTE_W-1:0] data);
        case (idx)
            dcp_pkg::REG_IN_HEIGHT:  in_h = data[dcp_pkg::DIM_W-1:0];
            dcp_pkg::REG_IN_WIDTH:   in_w = data[dcp_pkg::DIM_W-1:0];
            dcp_pkg::REG_OUT_HEIGHT: out_h = data[dcp_pkg::DIM_W-1:0];
            dcp_pkg::REG_OUT_WIDTH:  out_w = data[dcp_pkg::DIM_W-1:0];
            dcp_pkg::REG_KERNEL:     kern_reg = data;
            dcp_pkg::REG_PAD:        pad_reg = data;
            dcp_pkg::REG_STRIDE:     stride_reg = data;
            dcp_pkg::REG_DILATION:   dil_reg = data;
            default:                 ;
        endcase
    endfunction

    // every weight and pixel an output could touch has been written
    function bit outputs_readable();
        int n;
        n = kernel_taps();
        for (int i = 0; i < n; i++)
            if (!weight_loaded[i])
                return 1'b0;
        n = plane_pixels();
        for (int i = 0; i < n; i++)
            if (!pixel_loaded[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function void predict_plane_output();
        int kh, kw, ih, iw, oh, ow, pt, pl, sv, sh, dv, dh, r, c;
        longint acc;
        bit last;
        kh = clamp_tap(kern_reg[7:4]);
        kw = clamp_tap(kern_reg[3:0]);
        ih = clamp_size(in_h, dcp_pkg::MAX_HEIGHT);
        iw = clamp_size(in_w, dcp_pkg::MAX_WIDTH);
        oh = clamp_size(out_h, dcp_pkg::MAX_HEIGHT);
        ow = clamp_size(out_w, dcp_pkg::MAX_WIDTH);
        pt = int'(pad_reg[7:4]);
        pl = int'(pad_reg[3:0]);
        sv = nonzero(stride_reg[7:4]);
        sh = nonzero(stride_reg[3:0]);
        dv = nonzero(dil_reg[7:4]);
        dh = nonzero(dil_reg[3:0]);
        acc = 0;
        for (int a = 0; a < kh; a++) begin
            for (int b = 0; b < kw; b++) begin
                r = row * sv + a * dv - pt;
                c = col * sh + b * dh - pl;
                // padding taps add nothing
                if (r >= 0 && r < ih && c >= 0 && c < iw)
                    acc += longint'(weights[a * kw + b]) * longint'(pixels[r * iw + c]);
            end
        end
        last = (row + 1 >= oh) && (col + 1 >= ow);
        pending_sums.push_back(acc[dcp_pkg::ACC_W-1:0]);
        pending_last_flags.push_back(last);
        if (last) begin
            row = 0;
            col = 0;
        end
        else if (col + 1 >= ow) begin
            col = 0;
            row++;
        end
        else begin
            col++;
        end
    endfunction

    function void note_request(logic [dcp_pkg::MODE_W-1:0] md,
                               logic [dcp_pkg::SAMPLE_W-1:0] smp);
        int n;
        case (md)
            dcp_pkg::MODE_LOAD_WEIGHT: begin
                n = kernel_taps();
                if (weight_ptr >= n)
                    weight_ptr = 0;
                weights[weight_ptr] = smp;
                weight_loaded[weight_ptr] = 1'b1;
                weight_ptr++;
                if (weight_ptr >= n)
                    weight_ptr = 0;
            end
            dcp_pkg::MODE_LOAD_PIXEL: begin
                n = plane_pixels();
                if (pixel_ptr >= n)
                    pixel_ptr = 0;
                pixels[pixel_ptr] = smp;
                pixel_loaded[pixel_ptr] = 1'b1;
                pixel_ptr++;
                if (pixel_ptr >= n)
                    pixel_ptr = 0;
            end
            dcp_pkg::MODE_EMIT: predict_plane_output();
            default: ;
        endcase
    endfunction

    function void check_output(logic [dcp_pkg::ACC_W-1:0] value, logic last);
        logic [dcp_pkg::ACC_W-1:0] want_sum;
        bit want_last;
        if (pending_sums.size() == 0) begin
            $error("output with none pending: out_value %0d, last_of_plane %0b",
                   $signed(value), last);
            errors++;
            return;
        end
        want_sum = pending_sums.pop_front();
        want_last = pending_last_flags.pop_front();
        outputs_checked++;
        if (want_last)
            planes_closed++;
        if (value !== want_sum) begin
            $error("out_value mismatch: expected %0d, actual %0d",
                   $signed(want_sum), $signed(value));
            errors++;
        end
        if (last !== want_last) begin
            $error("last_of_plane mismatch: expected %0b, actual %0b", want_last, last);
            errors++;
        end
    endfunction

    function int pending();
        return pending_sums.size();
    endfunction
endclass

module depthwise_conv2d_plane_unit_tb;

    // one full register setting, one byte per register
    typedef struct packed {
        logic [7:0] in_h;
        logic [7:0] in_w;
        logic [7:0] out_h;
        logic [7:0] out_w;
        logic [7:0] kern;
        logic [7:0] pad;
        logic [7:0] stride;
        logic [7:0] dil;
    } plane_setting_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [dcp_pkg::MODE_W-1:0]   mode;
    logic [dcp_pkg::SAMPLE_W-1:0] sample;
    logic                         result_valid;
    logic [dcp_pkg::ACC_W-1:0]    out_value;
    logic                         last_of_plane;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [dcp_pkg::CFG_AW-1:0]   cfg_index;
    logic [dcp_pkg::BYTE_W-1:0]   cfg_data;

    conv_plane_scoreboard sb = new();

    // sender pacing: a bursty phase sends back to back
    bit bursty;

    // run statistics
    int weight_loads;
    int pixel_loads;
    int outputs_requested;
    int ignored_requests;
    int settings_applied;

    depthwise_conv2d_plane_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .sample        (sample),
        .result_valid  (result_valid),
        .out_value     (out_value),
        .last_of_plane (last_of_plane),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // every output lives one cycle, so check it at the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_output(out_value, last_of_plane);
    end

    // hard stop in case an output never shows up
    initial
    begin
        #2000000;
        $display("timeout: %0d outputs still pending", sb.pending());
        $display("FAIL");
        $finish;
    end

    // one request: optional idle gap, then hold start until busy is low
    task automatic send_request(input logic [dcp_pkg::MODE_W-1:0] md,
                                input logic [dcp_pkg::SAMPLE_W-1:0] smp);
        int gap;
        gap = bursty ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= md;
        sample <= smp;
        @(posedge clk);
        while (busy) @(posedge clk);
        // request taken at this edge
        sb.note_request(md, smp);
        case (md)
            dcp_pkg::MODE_LOAD_WEIGHT: weight_loads++;
            dcp_pkg::MODE_LOAD_PIXEL:  pixel_loads++;
            dcp_pkg::MODE_EMIT:        outputs_requested++;
            default:                   ignored_requests++;
        endcase
    endtask

    // stop sending, let every owed output arrive and the block go quiet
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        // loads and ignored requests leave no output to wait for
        repeat (8) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // valid stays high across back-to-back writes
    task automatic write_reg(input logic [dcp_pkg::CFG_AW-1:0] idx,
                             input logic [dcp_pkg::BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_register(idx, data);
    endtask

    task automatic apply_settings(input plane_setting_t s);
        write_reg(dcp_pkg::REG_IN_HEIGHT, s.in_h);
        write_reg(dcp_pkg::REG_IN_WIDTH, s.in_w);
        write_reg(dcp_pkg::REG_OUT_HEIGHT, s.out_h);
        write_reg(dcp_pkg::REG_OUT_WIDTH, s.out_w);
        write_reg(dcp_pkg::REG_KERNEL, s.kern);
        write_reg(dcp_pkg::REG_PAD, s.pad);
        write_reg(dcp_pkg::REG_STRIDE, s.stride);
        write_reg(dcp_pkg::REG_DILATION, s.dil);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // mostly small planes and kernels; zero and oversized fields now and then
    function automatic plane_setting_t random_setting();
        plane_setting_t s;
        s.in_h = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 8))};
        s.in_w = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 8))};
        s.out_h = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 9))};
        s.out_w = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 9))};
        s.kern = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        if ($urandom_range(0, 4) == 0)
            s.pad = 8'($urandom);
        else
            s.pad = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))};
        if ($urandom_range(0, 4) == 0)
            s.stride = 8'($urandom);
        else
            s.stride = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))};
        if ($urandom_range(0, 4) == 0)
            s.dil = 8'($urandom);
        else
            s.dil = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))};
        return s;
    endfunction

    // one phase: reprogram, load kernel and plane, then walk output positions
    // with stray loads and unused-mode requests mixed in
    task automatic run_phase(input plane_setting_t s, input int n_out, input bit partial);
        int n;
        int pick;
        settle();
        apply_settings(s);
        bursty = ($urandom_range(0, 3) == 0);
        // a partial load leaves the pointers mid-way for the next setting
        n = sb.kernel_taps();
        if (partial)
            n = $urandom_range(0, n);
        repeat (n) send_request(dcp_pkg::MODE_LOAD_WEIGHT, dcp_pkg::SAMPLE_W'($urandom));
        n = sb.plane_pixels();
        if (partial)
            n = $urandom_range(0, n);
        repeat (n) send_request(dcp_pkg::MODE_LOAD_PIXEL, dcp_pkg::SAMPLE_W'($urandom));
        for (int k = 0; k < n_out; k++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_request(dcp_pkg::MODE_LOAD_WEIGHT, dcp_pkg::SAMPLE_W'($urandom));
            else if (pick == 1)
                send_request(dcp_pkg::MODE_LOAD_PIXEL, dcp_pkg::SAMPLE_W'($urandom));
            else if (pick == 2)
                send_request(dcp_pkg::MODE_UNUSED, dcp_pkg::SAMPLE_W'($urandom));
            else if (sb.outputs_readable())
                // sample bits are don't-care on an output request
                send_request(dcp_pkg::MODE_EMIT, dcp_pkg::SAMPLE_W'($urandom));
        end
    endtask

    initial
    begin
        plane_setting_t s;
        rst_n <= 1'b0;
        start <= 1'b0;
        mode <= dcp_pkg::MODE_LOAD_WEIGHT;
        sample <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= dcp_pkg::REG_IN_HEIGHT;
        cfg_data <= '0;
        bursty = 1'b0;
        weight_loads = 0;
        pixel_loads = 0;
        outputs_requested = 0;
        ignored_requests = 0;
        settings_applied = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: 2x2 kernel over a 2x3 plane with full-scale samples
        settle();
        s = '{in_h: 8'd2, in_w: 8'd3, out_h: 8'd2, out_w: 8'd2,
              kern: 8'h22, pad: 8'h00, stride: 8'h11, dil: 8'h11};
        apply_settings(s);
        send_request(dcp_pkg::MODE_LOAD_WEIGHT, 16'h8000);
        send_request(dcp_pkg::MODE_LOAD_WEIGHT, 16'h8000);
        send_request(dcp_pkg::MODE_LOAD_WEIGHT, 16'h8000);
        send_request(dcp_pkg::MODE_LOAD_WEIGHT, 16'h7FFF);
        send_request(dcp_pkg::MODE_LOAD_PIXEL, 16'h8000);
        send_request(dcp_pkg::MODE_LOAD_PIXEL, 16'h7FFF);
        send_request(dcp_pkg::MODE_LOAD_PIXEL, 16'h8000);
        send_request(dcp_pkg::MODE_LOAD_PIXEL, 16'h8000);
        send_request(dcp_pkg::MODE_LOAD_PIXEL, 16'h0000);
        send_request(dcp_pkg::MODE_LOAD_PIXEL, 16'hFFFF);
        // unused mode must not move anything
        send_request(dcp_pkg::MODE_UNUSED, 16'hFFFF);
        send_request(dcp_pkg::MODE_EMIT, 16'h0000);
        send_request(dcp_pkg::MODE_EMIT, 16'hFFFF);
        send_request(dcp_pkg::MODE_EMIT, 16'h5555);
        // last position of the plane, flag set and wrap to the origin
        send_request(dcp_pkg::MODE_EMIT, 16'hAAAA);

        // tall single-column plane, 8x1 kernel, zero vertical stride
        s = '{in_h: 8'd64, in_w: 8'd1, out_h: 8'd64, out_w: 8'd1,
              kern: 8'h80, pad: 8'h30, stride: 8'h00, dil: 8'h10};
        run_phase(s, 66, 1'b0);

        // wide single-row plane, 1x8 kernel, left padding
        s = '{in_h: 8'd1, in_w: 8'd64, out_h: 8'd1, out_w: 8'd64,
              kern: 8'h08, pad: 8'h07, stride: 8'h00, dil: 8'h01};
        run_phase(s, 64, 1'b0);

        // all sizes zero count as one; largest stride and dilation
        s = '{in_h: 8'h80, in_w: 8'h00, out_h: 8'h00, out_w: 8'h80,
              kern: 8'h00, pad: 8'h00, stride: 8'hFF, dil: 8'hFF};
        run_phase(s, 3, 1'b0);

        // oversized fields saturate: 8x8 kernel, 64-row plane, full padding
        s = '{in_h: 8'h7F, in_w: 8'd2, out_h: 8'hFF, out_w: 8'd3,
              kern: 8'hFF, pad: 8'hFF, stride: 8'h12, dil: 8'h21};
        run_phase(s, 20, 1'b0);

        // random settings until enough requests have gone in
        while (weight_loads + pixel_loads + outputs_requested < 850)
            run_phase(random_setting(), $urandom_range(2, 30), $urandom_range(0, 5) == 0);

        start <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        // the longest output walks all 8x8 kernel taps
        repeat (80) @(posedge clk);

        $display("%0d weight loads, %0d pixel loads, %0d output requests, %0d ignored requests",
                 weight_loads, pixel_loads, outputs_requested, ignored_requests);
        $display("%0d register settings, %0d outputs checked, %0d plane ends seen",
                 settings_applied, sb.outputs_checked, sb.planes_closed);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
hdl/dcp_pkg.sv
hdl/dcp_store.sv
hdl/dcp_tap_seq.sv
hdl/dcp_mac.sv
hdl/depthwise_conv2d_plane_unit.sv
sim/depthwise_conv2d_plane_unit_tb.sv
